// ===== design/bmsrfp_pkg.sv =====
// Shared types, codes and constants for the battery monitor response frame parser.
package bmsrfp_pkg;

    // Default staging depth of one payload bank, in bytes
    localparam int PAYLOAD_DEPTH_DEF = 64;

    // Frame delimiters
    localparam logic [7:0] SOF_BYTE = 8'hDD;
    localparam logic [7:0] EOF_BYTE = 8'h77;
    localparam logic [7:0] STATUS_OK = 8'h00;

    // Registers that own a stored image
    localparam logic [7:0] REG_FIRST = 8'd3;
    localparam logic [7:0] REG_LAST  = 8'd5;

    // Bank pointer slots: 0..2 hold the images, 3 is the staging bank
    localparam logic [1:0] STAGE_SLOT    = 2'd3;
    localparam logic [7:0] BANK_MAP_INIT = 8'b11_10_01_00;

    // Image 3 layout
    localparam int IMG3_PAIR_END  = 18;  // plain pairs below this offset
    localparam int IMG3_N_POS     = 22;  // temperature count byte
    localparam int IMG3_TEMP_BASE = 23;  // first temperature pair

    // Transaction kinds
    localparam logic MODE_LINK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Image select codes
    localparam logic [1:0] IMG_REG3 = 2'd0;
    localparam logic [1:0] IMG_REG4 = 2'd1;
    localparam logic [1:0] IMG_REG5 = 2'd2;
    localparam logic [1:0] IMG_NONE = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_REG,
        PH_STATUS,
        PH_LEN,
        PH_PAYLOAD,
        PH_CKH,
        PH_CKL,
        PH_END
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_ACCEPTED    = 3'd1,
        EV_BAD_END     = 3'd2,
        EV_BAD_CKSUM   = 3'd3,
        EV_DEV_ERROR   = 3'd4,
        EV_UNKNOWN_REG = 3'd5
    } frame_event_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [1:0] image_sel;
        logic [5:0] read_index;
    } in_item_t;

    typedef struct packed {
        frame_event_t frame_event;
        logic [7:0]   frame_register;
        logic [7:0]   frame_length;
        logic [7:0]   read_data;
        logic         read_valid;
        logic [6:0]   image_length;
        logic [7:0]   status_seq;
    } out_item_t;

    // Frame close report from the parser, valid in the cycle of the step
    typedef struct packed {
        frame_event_t frame_event;
        logic [7:0]   frame_register;
        logic [7:0]   frame_length;
        logic [7:0]   status_seq;
    } frame_info_t;

endpackage

// ===== design/bms_response_frame_parser_core.sv =====
// Top level of the battery monitor response frame parser with image read port.
//
//  channel | valid     | ready     | payload | carries
//  --------+-----------+-----------+---------+---------------------------------
//  request | req_valid | req_ready | req     | link byte or image read transaction
//  result  | rsp_valid | rsp_ready | rsp     | one result per request transaction
//
// One request transaction is accepted every cycle while req_ready is high; its result
// passes the memory read stage, then the output register.
// The rate is set by the single payload memory: one access per transaction.
// A stalled result holds the output register; one more transaction waits in the
// read stage with its memory data held, and req_ready drops only when both are full.
// Reset clears parser, bank pointers and stored lengths, not the payload memory.
module bms_response_frame_parser_core
    import bmsrfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_item_t rsp
);

    localparam int IDX_W = $clog2(PAYLOAD_DEPTH);
    localparam int LEN_W = $clog2(PAYLOAD_DEPTH + 1);
    localparam int RAM_DEPTH = 4 << IDX_W;  // four banks, each padded to a power of two

    // Handshake and pipeline control
    logic        accept;
    logic        out_free;
    logic        s1_move;
    logic        s1_valid_reg, s1_valid_next;
    out_item_t   s1_item_reg, s1_item_next;
    logic        rsp_valid_reg, rsp_valid_next;
    out_item_t   rsp_reg, rsp_next;

    // Parser interface
    logic                  step;
    logic                  wr_en;
    logic [IDX_W+1:0]      wr_addr;
    logic [7:0]            wr_data;
    frame_info_t           info;
    logic [3:0][1:0]       bank_map;
    logic [2:0][LEN_W-1:0] stored_len;
    logic [7:0]            img3_b22;

    // Read address path
    logic                  rd_en;
    logic [IDX_W+1:0]      rd_addr;
    logic [7:0]            rd_data;
    logic                  sel_ok;
    logic [LEN_W-1:0]      ilen;
    logic [8:0]            ilen9;
    logic                  rvalid;
    logic [7:0]            temp_n;
    logic [9:0]            lim1, lim2, idx10;
    logic [6:0]            idx7, pair_even, pair_odd, p, p1, rd_idx7;
    logic                  in_pair;
    logic                  swap;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign accept   = req_valid && req_ready;
    assign step     = accept && (req.mode == MODE_LINK);
    assign rd_en    = accept && (req.mode == MODE_READ);

    bmsrfp_parser #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (req.rx_byte),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .info       (info),
        .bank_map   (bank_map),
        .stored_len (stored_len),
        .img3_b22   (img3_b22)
    );

    // Image lookup: length check, pair swap, partner offset.
    // Only committed banks give read data and only the staging bank is written, so a
    // read never meets a write to the same entry.
    always_comb
    begin
        sel_ok = (req.image_sel != IMG_NONE);
        ilen   = sel_ok ? stored_len[req.image_sel] : '0;
        ilen9  = 9'(ilen);
        idx7   = {1'b0, req.read_index};
        idx10  = 10'(req.read_index);
        rvalid = sel_ok && (9'(req.read_index) < ilen9);

        // temperature count, or the widest span when byte 22 is not stored
        temp_n = (ilen9 > 9'(IMG3_N_POS)) ? img3_b22 : 8'hFF;
        lim1   = 10'(IMG3_TEMP_BASE) + {1'b0, temp_n, 1'b0};
        lim2   = lim1 + 10'd1;

        pair_even = {idx7[6:1], 1'b0};
        pair_odd  = idx7[0] ? idx7 : (idx7 - 7'd1);

        in_pair = 1'b0;
        p       = pair_even;
        case (req.image_sel)
            IMG_REG3:
            begin
                if ((idx10 < 10'(IMG3_PAIR_END)) || (idx10 >= lim2))
                begin
                    in_pair = 1'b1;
                    p       = pair_even;
                end
                else if ((idx10 >= 10'(IMG3_TEMP_BASE)) && (idx10 < lim1))
                begin
                    // temperature pairs start on odd offsets
                    in_pair = 1'b1;
                    p       = pair_odd;
                end
            end
            IMG_REG4:
            begin
                in_pair = 1'b1;
                p       = pair_even;
            end
            default:
            begin
                in_pair = 1'b0;
            end
        endcase

        p1      = p + 7'd1;
        // a pair cut off by the stored length stays raw
        swap    = in_pair && (9'(p1) < ilen9);
        rd_idx7 = swap ? ((idx7 == p) ? p1 : p) : idx7;
        rd_addr = {bank_map[req.image_sel], IDX_W'(rd_idx7)};
    end

    bmsrfp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Stage 1 holds everything but the memory byte
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        if (accept)
        begin
            s1_valid_next               = 1'b1;
            s1_item_next.frame_event    = info.frame_event;
            s1_item_next.frame_register = info.frame_register;
            s1_item_next.frame_length   = info.frame_length;
            s1_item_next.read_data      = 8'd0;
            s1_item_next.read_valid     = rd_en && rvalid;
            s1_item_next.image_length   = rd_en ? 7'(ilen) : 7'd0;
            s1_item_next.status_seq     = info.status_seq;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Output register; read data is zero unless the read was in range
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (s1_move)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next           = s1_item_reg;
            rsp_next.read_data = s1_item_reg.read_valid ? rd_data : 8'd0;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== design/bmsrfp_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module bmsrfp_ram
    import bmsrfp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4 * PAYLOAD_DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bmsrfp_parser.sv =====
// Link byte deframer: phase machine, checksum, staging writes and bank commit.
module bmsrfp_parser
    import bmsrfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    localparam int IDX_W = $clog2(PAYLOAD_DEPTH),
    localparam int LEN_W = $clog2(PAYLOAD_DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               rx_byte,
    output logic                     wr_en,
    output logic [IDX_W+1:0]         wr_addr,
    output logic [7:0]               wr_data,
    output frame_info_t              info,
    output logic [3:0][1:0]          bank_map,
    output logic [2:0][LEN_W-1:0]    stored_len,
    output logic [7:0]               img3_b22
);

    localparam logic [7:0] DEPTH8 = 8'(PAYLOAD_DEPTH);

    phase_t               phase_reg, phase_next;
    logic [7:0]           hreg_reg, hreg_next;
    logic [7:0]           hstat_reg, hstat_next;
    logic [7:0]           hlen_reg, hlen_next;
    logic [7:0]           bc_reg, bc_next;
    logic [15:0]          sum_reg, sum_next;
    logic [7:0]           ckh_reg, ckh_next;
    logic [3:0][1:0]      map_reg, map_next;
    logic [2:0][LEN_W-1:0] slen_reg, slen_next;
    logic [7:0]           seq_reg, seq_next;
    logic [7:0]           stage_b22_reg, stage_b22_next;
    logic [7:0]           img3_b22_reg, img3_b22_next;
    logic [7:0]           count_inc;
    logic [1:0]           slot;
    logic                 known_reg;

    assign count_inc = bc_reg + 8'd1;
    assign slot      = 2'(hreg_reg - REG_FIRST);
    assign known_reg = (hreg_reg >= REG_FIRST) && (hreg_reg <= REG_LAST);

    always_comb
    begin : next_state
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HUNT:    if (rx_byte == SOF_BYTE) phase_next = PH_REG;
                PH_REG:     phase_next = PH_STATUS;
                PH_STATUS:  phase_next = PH_LEN;
                PH_LEN:     phase_next = (rx_byte == 8'd0) ? PH_CKH : PH_PAYLOAD;
                PH_PAYLOAD: if (count_inc >= hlen_reg) phase_next = PH_CKH;
                PH_CKH:     phase_next = PH_CKL;
                PH_CKL:     phase_next = PH_END;
                PH_END:     phase_next = PH_HUNT;
                default:    phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb
    begin : outputs
        hreg_next      = hreg_reg;
        hstat_next     = hstat_reg;
        hlen_next      = hlen_reg;
        bc_next        = bc_reg;
        sum_next       = sum_reg;
        ckh_next       = ckh_reg;
        map_next       = map_reg;
        slen_next      = slen_reg;
        seq_next       = seq_reg;
        stage_b22_next = stage_b22_reg;
        img3_b22_next  = img3_b22_reg;
        wr_en          = 1'b0;
        info.frame_event    = EV_NONE;
        info.frame_register = 8'd0;
        info.frame_length   = 8'd0;
        if (step)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                end
                PH_REG:
                begin
                    hreg_next = rx_byte;
                end
                PH_STATUS:
                begin
                    hstat_next = rx_byte;
                    sum_next   = {8'd0, rx_byte};
                end
                PH_LEN:
                begin
                    hlen_next = rx_byte;
                    sum_next  = sum_reg + {8'd0, rx_byte};
                    bc_next   = 8'd0;
                end
                PH_PAYLOAD:
                begin
                    // bytes past the bank depth count toward the sum only
                    wr_en = (bc_reg < DEPTH8);
                    if (bc_reg == 8'(IMG3_N_POS))
                    begin
                        stage_b22_next = rx_byte;
                    end
                    sum_next = sum_reg + {8'd0, rx_byte};
                    bc_next  = count_inc;
                end
                PH_CKH:
                begin
                    ckh_next = rx_byte;
                end
                PH_CKL:
                begin
                    sum_next = sum_reg + {ckh_reg, rx_byte};
                end
                PH_END:
                begin
                    info.frame_register = hreg_reg;
                    info.frame_length   = hlen_reg;
                    if (rx_byte != EOF_BYTE)
                    begin
                        info.frame_event = EV_BAD_END;
                    end
                    else if (sum_reg != 16'd0)
                    begin
                        info.frame_event = EV_BAD_CKSUM;
                    end
                    else if (hstat_reg != STATUS_OK)
                    begin
                        info.frame_event = EV_DEV_ERROR;
                    end
                    else if (known_reg)
                    begin
                        // commit: staging bank becomes the image, old image is the new stage
                        info.frame_event     = EV_ACCEPTED;
                        map_next[slot]       = map_reg[STAGE_SLOT];
                        map_next[STAGE_SLOT] = map_reg[slot];
                        slen_next[slot]      = (hlen_reg < DEPTH8) ? LEN_W'(hlen_reg)
                                                                   : LEN_W'(PAYLOAD_DEPTH);
                        if (slot == IMG_REG3)
                        begin
                            seq_next      = seq_reg + 8'd1;
                            img3_b22_next = stage_b22_reg;
                        end
                    end
                    else
                    begin
                        info.frame_event = EV_UNKNOWN_REG;
                    end
                end
                default:
                begin
                end
            endcase
        end
        info.status_seq = seq_next;
    end

    assign wr_addr    = {map_reg[STAGE_SLOT], bc_reg[IDX_W-1:0]};
    assign wr_data    = rx_byte;
    assign bank_map   = map_reg;
    assign stored_len = slen_reg;
    assign img3_b22   = img3_b22_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            hreg_reg      <= 8'd0;
            hstat_reg     <= 8'd0;
            hlen_reg      <= 8'd0;
            bc_reg        <= 8'd0;
            sum_reg       <= 16'd0;
            ckh_reg       <= 8'd0;
            map_reg       <= BANK_MAP_INIT;
            slen_reg      <= '0;
            seq_reg       <= 8'd0;
            stage_b22_reg <= 8'd0;
            img3_b22_reg  <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hreg_reg      <= hreg_next;
            hstat_reg     <= hstat_next;
            hlen_reg      <= hlen_next;
            bc_reg        <= bc_next;
            sum_reg       <= sum_next;
            ckh_reg       <= ckh_next;
            map_reg       <= map_next;
            slen_reg      <= slen_next;
            seq_reg       <= seq_next;
            stage_b22_reg <= stage_b22_next;
            img3_b22_reg  <= img3_b22_next;
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the battery monitor response frame parser core.
module testbench;
    import bmsrfp_pkg::*;

    localparam int DEPTH           = PAYLOAD_DEPTH_DEF;
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 300;

    // Ways a generated frame can be damaged
    localparam int FLAW_NONE  = 0;
    localparam int FLAW_END   = 1;
    localparam int FLAW_CKSUM = 2;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    in_item_t  req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_item_t rsp;

    bms_response_frame_parser_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle percentages for both sides, and how often reads are slipped into frames
    int send_idle_pct = 38;
    int recv_idle_pct = 80;
    int read_mix_pct  = 0;

    // Receiver hold-off: the test bumps the ticket, the receiver serves it
    int hold_off_ticket = 0;
    int hold_off_served = 0;
    int hold_off_left   = 0;

    int cycle_count   = 0;
    int errors        = 0;
    int useful_items  = 0;     // transactions that the parser does not simply drop
    int reads_in_range = 0;
    int outcome_tally [0:5] = '{default: 0};

    out_item_t responses_due [$];
    out_item_t got_want;

    // ------------------------------------------------------------------
    // Shadow copy of the parser state and the image memory
    // ------------------------------------------------------------------
    phase_t      sh_phase;
    logic [7:0]  sh_reg;
    logic [7:0]  sh_status;
    logic [7:0]  sh_len;
    logic [7:0]  sh_count;
    logic [7:0]  sh_ck_hi;
    logic [7:0]  sh_seq;
    logic [15:0] sh_sum;
    logic [7:0]  sh_mem [0:4*DEPTH-1];
    logic [1:0]  sh_bank [0:3];
    logic [6:0]  sh_img_len [0:2];

    task automatic reset_shadow();
        sh_phase  = PH_HUNT;
        sh_reg    = '0;
        sh_status = '0;
        sh_len    = '0;
        sh_count  = '0;
        sh_ck_hi  = '0;
        sh_seq    = '0;
        sh_sum    = '0;
        for (int i = 0; i < 4 * DEPTH; i++)
            sh_mem[i] = '0;
        for (int i = 0; i < 4; i++)
            sh_bank[i] = 2'(i);
        for (int i = 0; i < 3; i++)
            sh_img_len[i] = '0;
    endtask

    function automatic logic [7:0] bank_byte(input int slot, input int idx);
        return sh_mem[int'(sh_bank[slot]) * DEPTH + idx];
    endfunction

    // One image byte after the endian conversion. Image 3 has three swapped
    // regions (fixed pairs, n temperature pairs, everything from one byte past them); image 4
    // swaps all pairs; image 5 is raw. A pair cut off by the length stays raw.
    function automatic logic [7:0] image_byte(input int slot, input int idx, input int len);
        int n;
        int p;
        p = -1;
        if (slot == 0) begin
            n = (IMG3_N_POS < len) ? int'(bank_byte(0, IMG3_N_POS)) : 255;
            if (idx < IMG3_PAIR_END)
                p = idx & ~1;
            else if (idx >= IMG3_TEMP_BASE && idx < IMG3_TEMP_BASE + 2 * n)
                p = IMG3_TEMP_BASE + ((idx - IMG3_TEMP_BASE) & ~1);
            else if (idx >= IMG3_TEMP_BASE + 1 + 2 * n)
                p = IMG3_TEMP_BASE + 1 + 2 * n + ((idx - IMG3_TEMP_BASE - 1 - 2 * n) & ~1);
        end else if (slot == 1) begin
            p = idx & ~1;
        end
        if (p >= 0 && p + 1 < len)
            return bank_byte(slot, (idx == p) ? p + 1 : p);
        return bank_byte(slot, idx);
    endfunction

    // Advances the shadow state by one accepted transaction and returns the
    // result the block owes for it.
    task automatic compute_response(input in_item_t t, output out_item_t r);
        int         slot;
        logic [1:0] spare;
        r = '0;
        if (t.mode == MODE_READ) begin
            useful_items++;
            if (t.image_sel != IMG_NONE) begin
                r.image_length = sh_img_len[t.image_sel];
                if ({1'b0, t.read_index} < sh_img_len[t.image_sel]) begin
                    r.read_valid = 1'b1;
                    r.read_data  = image_byte(t.image_sel, t.read_index,
                                              sh_img_len[t.image_sel]);
                    reads_in_range++;
                end
            end
        end else begin
            if (sh_phase != PH_HUNT || t.rx_byte == SOF_BYTE)
                useful_items++;
            case (sh_phase)
                PH_HUNT:
                begin
                    if (t.rx_byte == SOF_BYTE)
                        sh_phase = PH_REG;
                end
                PH_REG:
                begin
                    sh_reg   = t.rx_byte;
                    sh_phase = PH_STATUS;
                end
                PH_STATUS:
                begin
                    sh_status = t.rx_byte;
                    sh_sum    = {8'h00, t.rx_byte};
                    sh_phase  = PH_LEN;
                end
                PH_LEN:
                begin
                    sh_len   = t.rx_byte;
                    sh_sum   = sh_sum + t.rx_byte;
                    sh_count = '0;
                    sh_phase = (t.rx_byte == 8'h00) ? PH_CKH : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    // bytes past the bank depth are summed but not stored
                    if (sh_count < DEPTH)
                        sh_mem[int'(sh_bank[STAGE_SLOT]) * DEPTH + sh_count] = t.rx_byte;
                    sh_sum   = sh_sum + t.rx_byte;
                    sh_count = sh_count + 8'd1;
                    if (sh_count >= sh_len)
                        sh_phase = PH_CKH;
                end
                PH_CKH:
                begin
                    sh_ck_hi = t.rx_byte;
                    sh_phase = PH_CKL;
                end
                PH_CKL:
                begin
                    sh_sum   = sh_sum + {sh_ck_hi, t.rx_byte};
                    sh_phase = PH_END;
                end
                default:
                begin
                    r.frame_register = sh_reg;
                    r.frame_length   = sh_len;
                    // precedence: end marker, checksum, status, register
                    if (t.rx_byte != EOF_BYTE) begin
                        r.frame_event = EV_BAD_END;
                    end else if (sh_sum != 16'h0000) begin
                        r.frame_event = EV_BAD_CKSUM;
                    end else if (sh_status != STATUS_OK) begin
                        r.frame_event = EV_DEV_ERROR;
                    end else if (sh_reg >= REG_FIRST && sh_reg <= REG_LAST) begin
                        // commit: the staged bank becomes the image, the old image
                        // bank becomes the new staging area
                        slot                = int'(sh_reg - REG_FIRST);
                        spare               = sh_bank[slot];
                        sh_bank[slot]       = sh_bank[STAGE_SLOT];
                        sh_bank[STAGE_SLOT] = spare;
                        sh_img_len[slot]    = (sh_len < DEPTH) ? sh_len[6:0] : 7'(DEPTH);
                        if (slot == 0)
                            sh_seq = sh_seq + 8'd1;
                        r.frame_event = EV_ACCEPTED;
                    end else begin
                        r.frame_event = EV_UNKNOWN_REG;
                    end
                    outcome_tally[r.frame_event]++;
                    sh_phase = PH_HUNT;
                end
            endcase
        end
        r.status_seq = sh_seq;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one transaction and waits for it to be taken. Valid is only lowered
    // when an idle gap is inserted, so back-to-back items keep it high.
    task automatic send_transaction(input in_item_t t);
        out_item_t r;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= t;
        do
            @(posedge clk);
        while (!req_ready);
        compute_response(t, r);
        responses_due.push_back(r);
    endtask

    task automatic send_link(input logic [7:0] b);
        in_item_t t;
        t.mode       = MODE_LINK;
        t.rx_byte    = b;
        t.image_sel  = 2'($urandom_range(0, 3));      // don't-care fields, kept random
        t.read_index = 6'($urandom_range(0, 63));
        send_transaction(t);
    endtask

    task automatic send_read(input logic [1:0] sel, input logic [5:0] idx);
        in_item_t t;
        t.mode       = MODE_READ;
        t.rx_byte    = 8'($urandom_range(0, 255));
        t.image_sel  = sel;
        t.read_index = idx;
        send_transaction(t);
    endtask

    // Mostly reads inside the stored image, some anywhere in the index range
    task automatic random_read();
        logic [1:0] sel;
        int         len;
        sel = 2'($urandom_range(0, 3));
        len = (sel == IMG_NONE) ? 0 : int'(sh_img_len[sel]);
        if (len > 0 && $urandom_range(0, 3) != 0)
            send_read(sel, 6'($urandom_range(0, len - 1)));
        else
            send_read(sel, 6'($urandom_range(0, 63)));
    endtask

    // Builds a complete frame with a correct checksum, then damages it as asked.
    // Reads may be slipped in between the bytes; they must not disturb the parser.
    task automatic send_frame(input logic [7:0] reg_no, input logic [7:0] status,
                              input int len, input int flaw);
        logic [7:0]  frame_bytes [$];
        logic [15:0] sum;
        logic [15:0] ck;
        logic [7:0]  b;
        frame_bytes = {};
        frame_bytes.push_back(SOF_BYTE);
        frame_bytes.push_back(reg_no);
        frame_bytes.push_back(status);
        frame_bytes.push_back(8'(len));
        sum = {8'h00, status} + {8'h00, 8'(len)};
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            // a small temperature count keeps all image 3 regions inside the bank
            if (reg_no == REG_FIRST && i == IMG3_N_POS && $urandom_range(0, 1) == 1)
                b = 8'($urandom_range(0, 20));
            frame_bytes.push_back(b);
            sum = sum + b;
        end
        ck = 16'h0000 - sum;
        if (flaw == FLAW_CKSUM)
            ck = ck ^ (16'h0001 << $urandom_range(0, 15));
        frame_bytes.push_back(ck[15:8]);
        frame_bytes.push_back(ck[7:0]);
        if (flaw == FLAW_END)
            frame_bytes.push_back(EOF_BYTE ^ 8'($urandom_range(1, 255)));
        else
            frame_bytes.push_back(EOF_BYTE);
        foreach (frame_bytes[i]) begin
            if ($urandom_range(0, 99) < read_mix_pct)
                random_read();
            send_link(frame_bytes[i]);
        end
    endtask

    function automatic logic [7:0] image_reg();
        if ($urandom_range(0, 9) < 4)
            return REG_FIRST;
        return REG_FIRST + 8'($urandom_range(1, 2));
    endfunction

    // Lengths mostly fit the bank; some run just past it, a few go all the way
    function automatic int frame_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            return $urandom_range(0, 40);
        if (pick < 97)
            return $urandom_range(41, 70);
        return $urandom_range(71, 255);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing stored yet: images 3 and 4 read as empty, and so does the unused select
    task automatic test_empty_reads();
        send_read(IMG_REG3, 6'd0);
        send_read(IMG_REG4, 6'd63);
        send_read(IMG_NONE, 6'd63);
    endtask

    // Zero-length frames that close with each outcome, plus stray bytes while hunting
    task automatic test_frame_outcomes();
        send_link(8'h00);
        send_link(8'hFF);
        send_frame(REG_LAST, STATUS_OK, 0, FLAW_NONE);
        send_read(IMG_REG5, 6'd0);                 // committed but empty
        send_frame(REG_LAST, STATUS_OK, 0, FLAW_END);
        send_frame(REG_FIRST, STATUS_OK, 0, FLAW_CKSUM);
        send_frame(REG_FIRST, 8'h80, 0, FLAW_NONE);
        send_frame(8'hFF, STATUS_OK, 0, FLAW_NONE);
    endtask

    // Mostly well-formed frames for the image registers with random content,
    // the rest damaged frames, foreign registers, noise, cut headers and reads
    task automatic test_random_traffic(input int count);
        int         target;
        int         pick;
        logic [7:0] reg_no;
        target = useful_items + count;
        while (useful_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame(image_reg(), STATUS_OK, frame_len(), FLAW_NONE);
            end else if (pick < 66) begin
                send_frame(image_reg(), 8'($urandom_range(0, 1)), frame_len(), FLAW_END);
            end else if (pick < 72) begin
                send_frame(image_reg(), 8'($urandom_range(0, 1)), frame_len(), FLAW_CKSUM);
            end else if (pick < 78) begin
                send_frame(image_reg(), 8'($urandom_range(1, 255)), frame_len(), FLAW_NONE);
            end else if (pick < 83) begin
                reg_no = 8'($urandom_range(0, 255));
                if (reg_no >= REG_FIRST && reg_no <= REG_LAST)
                    reg_no = reg_no ^ 8'h80;
                send_frame(reg_no, STATUS_OK, frame_len(), FLAW_NONE);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4))
                    send_link(8'($urandom_range(0, 255)));
            end else if (pick < 91) begin
                // header cut short: whatever follows is taken as the rest of it
                send_link(SOF_BYTE);
                send_link(8'($urandom_range(0, 255)));
                send_link(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8))
                    random_read();
            end
        end
    endtask

    // Receiver stops for a long stretch while the sender keeps going, so the
    // block fills both stages and must drop req_ready
    task automatic test_backpressure();
        hold_off_ticket <= hold_off_ticket + 1;
        repeat (20)
            random_read();
        send_frame(REG_FIRST, STATUS_OK, 30, FLAW_NONE);
    endtask

    // ------------------------------------------------------------------
    // Result side: drives rsp_ready and checks every result transaction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (responses_due.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, rsp);
                    errors++;
                end else begin
                    got_want = responses_due.pop_front();
                    check_field("frame_event", got_want.frame_event, rsp.frame_event);
                    check_field("frame_register", got_want.frame_register,
                                rsp.frame_register);
                    check_field("frame_length", got_want.frame_length, rsp.frame_length);
                    check_field("read_data", got_want.read_data, rsp.read_data);
                    check_field("read_valid", got_want.read_valid, rsp.read_valid);
                    check_field("image_length", got_want.image_length, rsp.image_length);
                    check_field("status_seq", got_want.status_seq, rsp.status_seq);
                end
            end
            if (hold_off_served != hold_off_ticket) begin
                hold_off_served = hold_off_ticket;
                hold_off_left   = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bms_response_frame_parser_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_shadow();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_reads();
        test_frame_outcomes();

        // sender idles little, receiver a lot; then the reverse; then neither
        read_mix_pct = 8;
        test_random_traffic(400);
        send_idle_pct = 80;
        recv_idle_pct = 38;
        test_random_traffic(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(400);
        test_backpressure();

        req_valid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d parser transactions: %0d frames accepted, %0d bad end, %0d bad checksum",
                 useful_items, outcome_tally[EV_ACCEPTED], outcome_tally[EV_BAD_END],
                 outcome_tally[EV_BAD_CKSUM]);
        $display("  %0d device errors, %0d unknown registers, %0d in-range image reads",
                 outcome_tally[EV_DEV_ERROR], outcome_tally[EV_UNKNOWN_REG], reads_in_range);
        if (errors == 0 && responses_due.size() == 0)
            $display("bms_response_frame_parser_core verification clean");
        else
            $display("bms_response_frame_parser_core verification failed");
        $finish;
    end

endmodule

// ===== bms_response_frame_parser_core.f =====
design/bmsrfp_pkg.sv
design/bmsrfp_ram.sv
design/bmsrfp_parser.sv
design/bms_response_frame_parser_core.sv
bench/testbench.sv
